>>> hw/rtl/server_outage_overload_monitor_macros.svh
// ---------------------------------------------------------------------------
// server outage overload monitor assertion macros
// concurrent check helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef SERVER_OUTAGE_OVERLOAD_MONITOR_MACROS_SVH
`define SERVER_OUTAGE_OVERLOAD_MONITOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define SOOM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SOOM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/soom_pkg.sv
// ---------------------------------------------------------------------------
// soom_pkg
// shared widths, codes and cell control types of the outage monitor
// ---------------------------------------------------------------------------
package soom_pkg;

    localparam int TS_W      = 47;
    localparam int ADDR_W    = 32;
    localparam int PRE_W     = 6;
    localparam int PING_W    = 16;
    localparam int RUN_W     = 10;
    localparam int LEN_W     = 5;
    localparam int THR_W     = 16;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W    = 6;

    localparam logic [RUN_W-1:0] RUN_MAX   = 10'd1023;
    localparam logic [RUN_W-1:0] LIMIT_RST = 10'd3;
    localparam logic [LEN_W-1:0] WLEN_RST  = 5'd3;
    localparam logic [THR_W-1:0] THR_RST   = 16'd100;

    typedef enum logic [KIND_W-1:0] {
        KIND_TROUBLE = 2'd0,
        KIND_BUSY    = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TROUBLE_LIMIT     = 2'd0,
        REG_WINDOW_LENGTH     = 2'd1,
        REG_LATENCY_THRESHOLD = 2'd2
    } t_reg_idx;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic wr_en;
        logic claim;
        logic tok_adv;
        logic clr_trouble;
        logic clr_busy;
    } t_cell_ctl;

    // status of one cell
    typedef struct packed {
        logic used;
        logic hit;
        logic first_free;
        logic trouble_open;
        logic busy_open;
    } t_cell_flags;

endpackage

>>> hw/rtl/soom_ram.sv
// ---------------------------------------------------------------------------
// soom_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module soom_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/soom_cell.sv
// ---------------------------------------------------------------------------
// soom_cell
// one server slot: key, trouble and busy period state, window bookkeeping
// ---------------------------------------------------------------------------
module soom_cell #(
    parameter int FILL_W = 5,
    parameter int HEAD_W = 4,
    parameter int TOT_W  = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  soom_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_sel,
    input  logic [soom_pkg::ADDR_W-1:0]   i_key_addr,
    input  logic [soom_pkg::PRE_W-1:0]    i_key_pre,
    input  logic                          i_prev_used,
    input  logic                          i_tok,
    output logic                          o_tok,
    output soom_pkg::t_cell_flags         o_flags,
    input  logic                          i_tr_open,
    input  logic [soom_pkg::TS_W-1:0]     i_tbeg,
    input  logic [soom_pkg::RUN_W-1:0]    i_run,
    input  logic                          i_busy_open,
    input  logic [soom_pkg::TS_W-1:0]     i_bbeg,
    input  logic [FILL_W-1:0]             i_fill,
    input  logic [HEAD_W-1:0]             i_head,
    input  logic [TOT_W-1:0]              i_total,
    output logic [soom_pkg::ADDR_W-1:0]   o_addr,
    output logic [soom_pkg::PRE_W-1:0]    o_pre,
    output logic [soom_pkg::TS_W-1:0]     o_tbeg,
    output logic [soom_pkg::RUN_W-1:0]    o_run,
    output logic [soom_pkg::TS_W-1:0]     o_bbeg,
    output logic [FILL_W-1:0]             o_fill,
    output logic [HEAD_W-1:0]             o_head,
    output logic [TOT_W-1:0]              o_total
);
    import soom_pkg::*;

    logic              r_used;
    logic              r_tr;
    logic [RUN_W-1:0]  r_run;
    logic              r_busy;
    logic [FILL_W-1:0] r_fill;
    logic [HEAD_W-1:0] r_head;
    logic [TOT_W-1:0]  r_total;
    logic              r_tok;
    logic [ADDR_W-1:0] r_addr;
    logic [PRE_W-1:0]  r_pre;
    logic [TS_W-1:0]   r_tbeg;
    logic [TS_W-1:0]   r_bbeg;
    logic              wr;

    assign wr = i_ctl.wr_en & i_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_tr    <= 1'b0;
            r_run   <= '0;
            r_busy  <= 1'b0;
            r_fill  <= '0;
            r_head  <= '0;
            r_total <= '0;
            r_tok   <= 1'b0;
        end else begin
            if (i_ctl.tok_adv) begin
                r_tok <= i_tok;
            end
            if (wr) begin
                if (i_ctl.claim) begin
                    r_used <= 1'b1;
                end
                r_tr    <= i_tr_open;
                r_run   <= i_run;
                r_busy  <= i_busy_open;
                r_fill  <= i_fill;
                r_head  <= i_head;
                r_total <= i_total;
            end else begin
                // flush walk closes periods as the token passes
                if (i_ctl.clr_trouble && r_tok) begin
                    r_tr  <= 1'b0;
                    r_run <= '0;
                end
                if (i_ctl.clr_busy && r_tok) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            if (i_ctl.claim) begin
                r_addr <= i_key_addr;
                r_pre  <= i_key_pre;
            end
            r_tbeg <= i_tbeg;
            r_bbeg <= i_bbeg;
        end
    end

    assign o_tok                = r_tok;
    assign o_flags.used         = r_used;
    assign o_flags.hit          = r_used && (r_addr == i_key_addr) && (r_pre == i_key_pre);
    assign o_flags.first_free   = !r_used && i_prev_used;
    assign o_flags.trouble_open = r_tr;
    assign o_flags.busy_open    = r_busy;
    assign o_addr  = r_addr;
    assign o_pre   = r_pre;
    assign o_tbeg  = r_tbeg;
    assign o_run   = r_run;
    assign o_bbeg  = r_bbeg;
    assign o_fill  = r_fill;
    assign o_head  = r_head;
    assign o_total = r_total;

endmodule

>>> hw/rtl/server_outage_overload_monitor.sv
// ---------------------------------------------------------------------------
// server_outage_overload_monitor
// per-server ping timeout and moving average latency monitor
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one log record or flush command per beat; tuser is cmd
//   (1 = flush). m_axis gives result beats, tuser is the kind, tlast marks
//   the final result of one input beat. a beat with no result gives nothing.
//   cfg: i_cfg_we writes i_cfg_data to register i_cfg_index. the user must
//   write only while idle; the block itself does not enforce it.
// timing:
//   one item is worked at a time. a record is looked up; a dropped one goes to
//   finish, the others are loaded and pass the trouble step. a timeout then
//   writes back; a ping drops the oldest window samples until one place is
//   free, puts, compares and writes back. the key match is a parallel compare
//   in every cell. a flush walks a token down the row: troubles, then busy.
// reset:
//   synchronous, active low; all slots free, registers back to 3 / 3 / 100.
//   no clearing pass is needed, the sample ram is read only where written.
// stall:
//   results wait in an output register plus one staging register; when
//   m_axis_tready stays low the walk or record holds until room opens.
// ---------------------------------------------------------------------------
`include "server_outage_overload_monitor_macros.svh"

module server_outage_overload_monitor #(
    parameter int ENTRIES    = 16,
    parameter int MAX_WINDOW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: timestamp[46:0], server_address[78:47], prefix_len[84:79],
    //        timed_out[85], ping_ms[101:86], zero pad[103:102]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [103:0]                   s_axis_tdata,
    // tuser: cmd[0]
    input  logic                           s_axis_tuser,
    // tdata: out_address[31:0], out_prefix[37:32], start_time[84:38],
    //        end_time[131:85], end_open[132], zero pad[135:133]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [135:0]                   m_axis_tdata,
    // tuser: kind[1:0]
    output logic [soom_pkg::KIND_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [soom_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [soom_pkg::CFG_W-1:0]     i_cfg_data
);
    import soom_pkg::*;

    localparam int SW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HEAD_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int TOT_W  = PING_W + FILL_W;
    localparam int LIM_W  = FILL_W + THR_W;
    localparam int PW     = FILL_W + 1;
    localparam int RAM_AW = SW + HEAD_W;
    localparam int RAM_D  = 2 ** RAM_AW;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_LOOK     = 12'b000000000010,
        S_LOAD     = 12'b000000000100,
        S_TRBL     = 12'b000000001000,
        S_SHRINK   = 12'b000000010000,
        S_SHRINK_W = 12'b000000100000,
        S_PUT      = 12'b000001000000,
        S_CMP      = 12'b000010000000,
        S_WB       = 12'b000100000000,
        S_FL_TR    = 12'b001000000000,
        S_FL_BS    = 12'b010000000000,
        S_FINISH   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [RUN_W-1:0] r_limit;
    logic [LEN_W-1:0] r_wlen;
    logic [THR_W-1:0] r_thr;
    logic [FILL_W-1:0] eff_len;

    // captured record
    logic [TS_W-1:0]   r_in_ts;
    logic [ADDR_W-1:0] r_in_addr;
    logic [PRE_W-1:0]  r_in_pre;
    logic              r_in_tmo;
    logic [PING_W-1:0] r_in_ping;

    // working copy of the selected slot
    logic [ENTRIES-1:0] r_slot_oh, n_slot_oh;
    logic [SW-1:0]      r_slot_bin, n_slot_bin;
    logic               r_new, n_new;
    logic               r_cur_tr, n_cur_tr;
    logic [TS_W-1:0]    r_cur_tbeg, n_cur_tbeg;
    logic [RUN_W-1:0]   r_cur_run, n_cur_run;
    logic               r_cur_busy, n_cur_busy;
    logic [TS_W-1:0]    r_cur_bbeg, n_cur_bbeg;
    logic [FILL_W-1:0]  r_cur_fill, n_cur_fill;
    logic [HEAD_W-1:0]  r_cur_head, n_cur_head;
    logic [TOT_W-1:0]   r_cur_total, n_cur_total;
    logic [LIM_W-1:0]   r_lim;
    logic [SW-1:0]      r_idx, n_idx;
    logic [NRES_W-1:0]  r_nres;

    // cell row
    t_cell_ctl          ctl;
    t_cell_flags        c_flags [ENTRIES];
    logic [ENTRIES-1:0] c_tok;
    logic [ADDR_W-1:0]  c_addr  [ENTRIES];
    logic [PRE_W-1:0]   c_pre   [ENTRIES];
    logic [TS_W-1:0]    c_tbeg  [ENTRIES];
    logic [RUN_W-1:0]   c_run   [ENTRIES];
    logic [TS_W-1:0]    c_bbeg  [ENTRIES];
    logic [FILL_W-1:0]  c_fill  [ENTRIES];
    logic [HEAD_W-1:0]  c_head  [ENTRIES];
    logic [TOT_W-1:0]   c_total [ENTRIES];
    logic               tok_start;
    logic [ENTRIES-1:0] hit_vec, free_vec, mux_sel;

    // selected cell view
    logic [ADDR_W-1:0]  m_addr;
    logic [PRE_W-1:0]   m_pre;
    logic [TS_W-1:0]    m_tbeg;
    logic [RUN_W-1:0]   m_run;
    logic [TS_W-1:0]    m_bbeg;
    logic [FILL_W-1:0]  m_fill;
    logic [HEAD_W-1:0]  m_head;
    logic [TOT_W-1:0]   m_total;
    logic               m_tr;
    logic               m_busy;

    // staging and output registers
    logic               st_req;
    logic [KIND_W-1:0]  st_kind;
    logic [ADDR_W-1:0]  st_addr;
    logic [PRE_W-1:0]   st_pre;
    logic [TS_W-1:0]    st_start;
    logic [TS_W-1:0]    st_end;
    logic               st_open;
    logic               grant, out_free, out_ld, out_last, fin_ld;
    logic               r_stg_v;
    logic [KIND_W-1:0]  r_stg_kind;
    logic [ADDR_W-1:0]  r_stg_addr;
    logic [PRE_W-1:0]   r_stg_pre;
    logic [TS_W-1:0]    r_stg_start;
    logic [TS_W-1:0]    r_stg_end;
    logic               r_stg_open;
    logic               r_ov;
    logic               r_o_last;
    logic [KIND_W-1:0]  r_o_kind;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [PRE_W-1:0]   r_o_pre;
    logic [TS_W-1:0]    r_o_start;
    logic [TS_W-1:0]    r_o_end;
    logic               r_o_open;

    // window ram
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
    logic [PING_W-1:0]   ram_rdata;
    logic [PW-1:0]       pos_sum;
    logic [HEAD_W-1:0]   pos;

    logic in_acc;
    logic fill_hit, tot_ge;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
            r_wlen  <= WLEN_RST;
            r_thr   <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TROUBLE_LIMIT:     r_limit <= i_cfg_data[RUN_W-1:0];
                REG_WINDOW_LENGTH:     r_wlen  <= i_cfg_data[LEN_W-1:0];
                REG_LATENCY_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything past the window depth acts as the depth
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = FILL_W'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            eff_len = FILL_W'(MAX_WINDOW);
        end else begin
            eff_len = FILL_W'(r_wlen);
        end
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic prev_used;
        logic tok_in;
        if (g == 0) begin : g_first
            assign prev_used = 1'b1;
            assign tok_in    = tok_start;
        end else begin : g_rest
            assign prev_used = c_flags[g-1].used;
            assign tok_in    = c_tok[g-1];
        end

        soom_cell #(
            .FILL_W (FILL_W),
            .HEAD_W (HEAD_W),
            .TOT_W  (TOT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_sel       (r_slot_oh[g]),
            .i_key_addr  (r_in_addr),
            .i_key_pre   (r_in_pre),
            .i_prev_used (prev_used),
            .i_tok       (tok_in),
            .o_tok       (c_tok[g]),
            .o_flags     (c_flags[g]),
            .i_tr_open   (r_cur_tr),
            .i_tbeg      (r_cur_tbeg),
            .i_run       (r_cur_run),
            .i_busy_open (r_cur_busy),
            .i_bbeg      (r_cur_bbeg),
            .i_fill      (r_cur_fill),
            .i_head      (r_cur_head),
            .i_total     (r_cur_total),
            .o_addr      (c_addr[g]),
            .o_pre       (c_pre[g]),
            .o_tbeg      (c_tbeg[g]),
            .o_run       (c_run[g]),
            .o_bbeg      (c_bbeg[g]),
            .o_fill      (c_fill[g]),
            .o_head      (c_head[g]),
            .o_total     (c_total[g])
        );

        assign hit_vec[g]  = c_flags[g].hit;
        assign free_vec[g] = c_flags[g].first_free;
    end

    // the token picks the cell during a flush walk, the record slot otherwise
    assign mux_sel = (r_state == S_FL_TR || r_state == S_FL_BS) ? c_tok : r_slot_oh;

    always_comb begin
        m_addr  = '0;
        m_pre   = '0;
        m_tbeg  = '0;
        m_run   = '0;
        m_bbeg  = '0;
        m_fill  = '0;
        m_head  = '0;
        m_total = '0;
        m_tr    = 1'b0;
        m_busy  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            m_addr  |= {ADDR_W{mux_sel[i]}} & c_addr[i];
            m_pre   |= {PRE_W{mux_sel[i]}}  & c_pre[i];
            m_tbeg  |= {TS_W{mux_sel[i]}}   & c_tbeg[i];
            m_run   |= {RUN_W{mux_sel[i]}}  & c_run[i];
            m_bbeg  |= {TS_W{mux_sel[i]}}   & c_bbeg[i];
            m_fill  |= {FILL_W{mux_sel[i]}} & c_fill[i];
            m_head  |= {HEAD_W{mux_sel[i]}} & c_head[i];
            m_total |= {TOT_W{mux_sel[i]}}  & c_total[i];
            m_tr    |= mux_sel[i] & c_flags[i].trouble_open;
            m_busy  |= mux_sel[i] & c_flags[i].busy_open;
        end
    end

    // ---------------- window ram ----------------
    assign pos_sum   = PW'(r_cur_head) + PW'(r_cur_fill);
    assign pos       = (pos_sum >= PW'(MAX_WINDOW)) ? HEAD_W'(pos_sum - PW'(MAX_WINDOW))
                                                    : HEAD_W'(pos_sum);
    assign ram_we    = (r_state == S_PUT);
    assign ram_waddr = {r_slot_bin, pos};
    assign ram_raddr = {r_slot_bin, r_cur_head};

    soom_ram #(
        .WIDTH (PING_W),
        .DEPTH (RAM_D)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_in_ping),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign fill_hit = (r_cur_fill == eff_len);
    assign tot_ge   = (LIM_W'(r_cur_total) >= r_lim);

    // ---------------- control ----------------
    assign out_free = !r_ov || m_axis_tready;
    assign grant    = !r_stg_v || out_free;

    always_comb begin
        n_state     = r_state;
        n_slot_oh   = r_slot_oh;
        n_slot_bin  = r_slot_bin;
        n_new       = r_new;
        n_cur_tr    = r_cur_tr;
        n_cur_tbeg  = r_cur_tbeg;
        n_cur_run   = r_cur_run;
        n_cur_busy  = r_cur_busy;
        n_cur_bbeg  = r_cur_bbeg;
        n_cur_fill  = r_cur_fill;
        n_cur_head  = r_cur_head;
        n_cur_total = r_cur_total;
        n_idx       = r_idx;
        ctl         = '0;
        tok_start   = 1'b0;
        st_req      = 1'b0;
        st_kind     = KIND_TROUBLE;
        st_addr     = r_in_addr;
        st_pre      = r_in_pre;
        st_start    = r_in_ts;
        st_end      = '0;
        st_open     = 1'b0;
        fin_ld      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        ctl.tok_adv = 1'b1;
                        tok_start   = 1'b1;
                        n_idx       = '0;
                        n_state     = S_FL_TR;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (|hit_vec) begin
                    n_slot_oh = hit_vec;
                    n_new     = 1'b0;
                    n_state   = S_LOAD;
                end else if (|free_vec) begin
                    n_slot_oh = free_vec;
                    n_new     = 1'b1;
                    n_state   = S_LOAD;
                end else begin
                    // table full: the record is dropped with one result
                    st_req   = 1'b1;
                    st_kind  = KIND_DROP;
                    n_state  = S_FINISH;
                end
                n_slot_bin = '0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (n_slot_oh[i]) begin
                        n_slot_bin |= SW'(i);
                    end
                end
            end
            S_LOAD: begin
                n_cur_tbeg = m_tbeg;
                n_cur_bbeg = m_bbeg;
                if (r_new) begin
                    n_cur_tr    = 1'b0;
                    n_cur_run   = '0;
                    n_cur_busy  = 1'b0;
                    n_cur_fill  = '0;
                    n_cur_head  = '0;
                    n_cur_total = '0;
                end else begin
                    n_cur_tr    = m_tr;
                    n_cur_run   = m_run;
                    n_cur_busy  = m_busy;
                    n_cur_fill  = m_fill;
                    n_cur_head  = m_head;
                    n_cur_total = m_total;
                end
                n_state = S_TRBL;
            end
            S_TRBL: begin
                if (r_in_tmo) begin
                    if (!r_cur_tr) begin
                        n_cur_tr   = 1'b1;
                        n_cur_tbeg = r_in_ts;
                        n_cur_run  = RUN_W'(1);
                    end else if (r_cur_run < RUN_MAX) begin
                        n_cur_run = r_cur_run + RUN_W'(1);
                    end
                    n_state = S_WB;
                end else begin
                    // staging is empty here, so the report always fits
                    if (r_cur_tr && (r_cur_run >= r_limit)) begin
                        st_req   = 1'b1;
                        st_kind  = KIND_TROUBLE;
                        st_start = r_cur_tbeg;
                        st_end   = r_in_ts;
                    end
                    n_cur_tr  = 1'b0;
                    n_cur_run = '0;
                    n_state   = S_SHRINK;
                end
            end
            S_SHRINK: begin
                if (r_cur_fill >= eff_len) begin
                    n_state = S_SHRINK_W;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_SHRINK_W: begin
                n_cur_total = r_cur_total - TOT_W'(ram_rdata);
                n_cur_head  = (r_cur_head == HEAD_W'(MAX_WINDOW - 1)) ? '0
                                                                     : r_cur_head + HEAD_W'(1);
                n_cur_fill  = r_cur_fill - FILL_W'(1);
                n_state     = S_SHRINK;
            end
            S_PUT: begin
                n_cur_total = r_cur_total + TOT_W'(r_in_ping);
                n_cur_fill  = r_cur_fill + FILL_W'(1);
                n_state     = S_CMP;
            end
            S_CMP: begin
                n_state = S_WB;
                if (fill_hit) begin
                    if (tot_ge) begin
                        if (!r_cur_busy) begin
                            n_cur_busy = 1'b1;
                            n_cur_bbeg = r_in_ts;
                        end
                    end else if (r_cur_busy) begin
                        if (grant) begin
                            st_req     = 1'b1;
                            st_kind    = KIND_BUSY;
                            st_start   = r_cur_bbeg;
                            st_end     = r_in_ts;
                            n_cur_busy = 1'b0;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_WB: begin
                ctl.wr_en = 1'b1;
                ctl.claim = r_new;
                n_state   = S_FINISH;
            end
            S_FL_TR: begin
                if (m_tr && (m_run >= r_limit) && (r_nres < NRES_W'(MAX_RESULTS))) begin
                    st_req   = grant;
                    st_kind  = KIND_TROUBLE;
                    st_addr  = m_addr;
                    st_pre   = m_pre;
                    st_start = m_tbeg;
                    st_open  = 1'b1;
                end
                if (st_req || !(m_tr && (m_run >= r_limit) &&
                                (r_nres < NRES_W'(MAX_RESULTS)))) begin
                    ctl.clr_trouble = 1'b1;
                    ctl.tok_adv     = 1'b1;
                    n_idx           = r_idx + SW'(1);
                    if (r_idx == SW'(ENTRIES - 1)) begin
                        // token wraps to the head of the row for the busy pass
                        tok_start = 1'b1;
                        n_idx     = '0;
                        n_state   = S_FL_BS;
                    end
                end
            end
            S_FL_BS: begin
                if (m_busy && (r_nres < NRES_W'(MAX_RESULTS))) begin
                    st_req   = grant;
                    st_kind  = KIND_BUSY;
                    st_addr  = m_addr;
                    st_pre   = m_pre;
                    st_start = m_bbeg;
                    st_open  = 1'b1;
                end
                if (st_req || !(m_busy && (r_nres < NRES_W'(MAX_RESULTS)))) begin
                    ctl.clr_busy = 1'b1;
                    ctl.tok_adv  = 1'b1;
                    n_idx        = r_idx + SW'(1);
                    if (r_idx == SW'(ENTRIES - 1)) begin
                        n_idx   = '0;
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!r_stg_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    fin_ld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a new staged result pushes the older one out; the last one leaves at finish
    assign out_ld   = fin_ld || (st_req && r_stg_v);
    assign out_last = fin_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot_oh <= '0;
            r_new     <= 1'b0;
            r_idx     <= '0;
            r_nres    <= '0;
            r_stg_v   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot_oh <= n_slot_oh;
            r_new     <= n_new;
            r_idx     <= n_idx;
            if (in_acc) begin
                r_nres <= '0;
            end else if (st_req) begin
                r_nres <= r_nres + NRES_W'(1);
            end
            if (st_req) begin
                r_stg_v <= 1'b1;
            end else if (fin_ld) begin
                r_stg_v <= 1'b0;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_ts   <= s_axis_tdata[46:0];
            r_in_addr <= s_axis_tdata[78:47];
            r_in_pre  <= s_axis_tdata[84:79];
            r_in_tmo  <= s_axis_tdata[85];
            r_in_ping <= s_axis_tdata[101:86];
        end
        r_slot_bin  <= n_slot_bin;
        r_cur_tr    <= n_cur_tr;
        r_cur_tbeg  <= n_cur_tbeg;
        r_cur_run   <= n_cur_run;
        r_cur_busy  <= n_cur_busy;
        r_cur_bbeg  <= n_cur_bbeg;
        r_cur_fill  <= n_cur_fill;
        r_cur_head  <= n_cur_head;
        r_cur_total <= n_cur_total;
        if (r_state == S_PUT) begin
            r_lim <= LIM_W'(eff_len) * LIM_W'(r_thr);
        end
        if (st_req) begin
            r_stg_kind  <= st_kind;
            r_stg_addr  <= st_addr;
            r_stg_pre   <= st_pre;
            r_stg_start <= st_start;
            r_stg_end   <= st_end;
            r_stg_open  <= st_open;
        end
        if (out_ld) begin
            r_o_last  <= out_last;
            r_o_kind  <= r_stg_kind;
            r_o_addr  <= r_stg_addr;
            r_o_pre   <= r_stg_pre;
            r_o_start <= r_stg_start;
            r_o_end   <= r_stg_end;
            r_o_open  <= r_stg_open;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {3'b000, r_o_open, r_o_end, r_o_start, r_o_pre, r_o_addr};

    // ---------------- checks ----------------
    `SOOM_ASSERT_IMP(a_key_unique, r_state == S_LOOK, $onehot0(hit_vec), "duplicate key in table")
    `SOOM_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(c_tok), "more than one flush token")
    `SOOM_ASSERT_IMP(a_idle_drained, r_state == S_IDLE, !r_stg_v, "staged result left at idle")
    `SOOM_ASSERT_IMP(a_nres_cap, 1'b1, r_nres <= NRES_W'(MAX_RESULTS), "result count overrun")
    `SOOM_ASSERT_NXT(a_flush_walk, in_acc && s_axis_tuser, r_state == S_FL_TR, "flush did not start walk")

endmodule

>>> tb/tb_server_outage_overload_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_server_outage_overload_monitor
// self-checking bench for the per-server outage and overload monitor:
// log records and flushes are driven on the input stream, a scoreboard
// predicts trouble, busy and drop results and checks every output beat
// ---------------------------------------------------------------------------
module tb_server_outage_overload_monitor;
    import soom_pkg::*;

    localparam int SLOTS    = 16;
    localparam int WIN_MAX  = 16;
    localparam int NKEYS    = 20;
    localparam int SETTLE   = 40;

    // one input beat, decoded
    typedef struct {
        bit         flush;
        logic [46:0] ts;
        logic [31:0] addr;
        logic [5:0]  pre;
        bit         tmo;
        logic [15:0] ping;
    } t_record;

    // one result beat
    typedef struct {
        t_kind       kind;
        logic [31:0] addr;
        logic [5:0]  pre;
        logic [46:0] start;
        logic [46:0] stop;
        bit          open;
        bit          last;
    } t_result;

    // -----------------------------------------------------------------------
    // scoreboard: health table predictor plus queue of expected results
    // -----------------------------------------------------------------------
    class monitor_scoreboard;
        logic [9:0]  limit;
        logic [4:0]  wlen;
        logic [15:0] thr;
        bit          used [SLOTS];
        logic [31:0] saddr [SLOTS];
        logic [5:0]  spre [SLOTS];
        bit          topen [SLOTS];
        logic [46:0] tbeg [SLOTS];
        int unsigned run [SLOTS];
        bit          bopen [SLOTS];
        logic [46:0] bbeg [SLOTS];
        int unsigned samp [SLOTS][WIN_MAX];
        int unsigned fill [SLOTS];
        int unsigned head [SLOTS];
        int unsigned total [SLOTS];
        t_result     pending_q [$];
        int          errors;

        function void clear();
            limit = 10'd3;
            wlen  = 5'd3;
            thr   = 16'd100;
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0; topen[i] = 0; run[i] = 0; bopen[i] = 0;
                fill[i] = 0; head[i] = 0; total[i] = 0;
            end
            pending_q.delete();
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [15:0] v);
            case (idx)
                REG_TROUBLE_LIMIT:     limit = v[9:0];
                REG_WINDOW_LENGTH:     wlen  = v[4:0];
                REG_LATENCY_THRESHOLD: thr   = v;
                default: ;
            endcase
        endfunction

        function void push(t_kind k, logic [31:0] a, logic [5:0] p,
                           logic [46:0] st, logic [46:0] sp, bit o);
            t_result r;
            r.kind = k; r.addr = a; r.pre = p; r.start = st; r.stop = sp;
            r.open = o; r.last = 0;
            pending_q.push_back(r);
        endfunction

        // works out the results of one accepted beat
        function void note_record(t_record r);
            int          s;
            int          n0;
            int unsigned len;
            int unsigned pos;
            longint unsigned lim;
            n0 = pending_q.size();
            if (r.flush) begin
                // troubles first, then busy periods, both in slot order
                for (int i = 0; i < SLOTS; i++) begin
                    if (topen[i] && run[i] >= limit)
                        push(KIND_TROUBLE, saddr[i], spre[i], tbeg[i], '0, 1);
                    topen[i] = 0;
                    run[i]   = 0;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (bopen[i])
                        push(KIND_BUSY, saddr[i], spre[i], bbeg[i], '0, 1);
                    bopen[i] = 0;
                end
            end else begin
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && used[i] && saddr[i] == r.addr && spre[i] == r.pre) s = i;
                if (s < 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && !used[i]) s = i;
                    if (s >= 0) begin
                        used[s] = 1; saddr[s] = r.addr; spre[s] = r.pre;
                        topen[s] = 0; run[s] = 0; bopen[s] = 0;
                        fill[s] = 0; head[s] = 0; total[s] = 0;
                    end
                end
                if (s < 0) begin
                    // table full: dropped, state untouched
                    push(KIND_DROP, r.addr, r.pre, r.ts, '0, 0);
                end else if (r.tmo) begin
                    if (!topen[s]) begin
                        topen[s] = 1; tbeg[s] = r.ts; run[s] = 1;
                    end else if (run[s] < 1023) begin
                        run[s]++;
                    end
                end else begin
                    if (topen[s]) begin
                        if (run[s] >= limit)
                            push(KIND_TROUBLE, r.addr, r.pre, tbeg[s], r.ts, 0);
                        topen[s] = 0;
                        run[s]   = 0;
                    end
                    len = (wlen == 0) ? 1 : (wlen > WIN_MAX) ? WIN_MAX : wlen;
                    // a full or shrunk window drops oldest samples until one place is free
                    while (fill[s] >= len) begin
                        total[s] -= samp[s][head[s]];
                        head[s] = (head[s] + 1) % WIN_MAX;
                        fill[s]--;
                    end
                    pos = (head[s] + fill[s]) % WIN_MAX;
                    samp[s][pos] = r.ping;
                    total[s] += r.ping;
                    fill[s]++;
                    if (fill[s] == len) begin
                        lim = longint'(len) * thr;
                        if (longint'(total[s]) >= lim) begin
                            if (!bopen[s]) begin
                                bopen[s] = 1; bbeg[s] = r.ts;
                            end
                        end else if (bopen[s]) begin
                            push(KIND_BUSY, r.addr, r.pre, bbeg[s], r.ts, 0);
                            bopen[s] = 0;
                        end
                    end
                end
            end
            if (pending_q.size() > n0) pending_q[pending_q.size()-1].last = 1;
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (pending_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            exp = pending_q.pop_front();
            if (got.kind != exp.kind)
                report_mismatch($sformatf("kind %0d exp %0d", got.kind, exp.kind));
            if (got.addr != exp.addr)
                report_mismatch($sformatf("address %h exp %h", got.addr, exp.addr));
            if (got.pre != exp.pre)
                report_mismatch($sformatf("prefix %0d exp %0d", got.pre, exp.pre));
            if (got.start != exp.start)
                report_mismatch($sformatf("start %0d exp %0d", got.start, exp.start));
            if (got.stop != exp.stop)
                report_mismatch($sformatf("end %0d exp %0d", got.stop, exp.stop));
            if (got.open != exp.open)
                report_mismatch($sformatf("end_open %0d exp %0d", got.open, exp.open));
            if (got.last != exp.last)
                report_mismatch($sformatf("tlast %0d exp %0d", got.last, exp.last));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, dut, signals
    // -----------------------------------------------------------------------
    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata = '0;
    logic                 s_axis_tuser = 0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [135:0]         m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    server_outage_overload_monitor dut (.*);

    monitor_scoreboard health_sb = new();

    // stimulus knobs
    bit          no_idle = 0;      // long stretch without gaps on either side
    int          hold_cycles = 0;  // receiver back-pressure counter
    logic [31:0] key_addr [NKEYS];
    logic [5:0]  key_pre [NKEYS];

    // -----------------------------------------------------------------------
    // receiver: random tready, plus long hold-off when asked
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready = 0;
            hold_cycles--;
        end else begin
            m_axis_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    // -----------------------------------------------------------------------
    // beat monitor: accepted inputs feed the predictor, results get checked
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_record rec;
        t_result res;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rec.flush = s_axis_tuser;
            rec.ts    = s_axis_tdata[46:0];
            rec.addr  = s_axis_tdata[78:47];
            rec.pre   = s_axis_tdata[84:79];
            rec.tmo   = s_axis_tdata[85];
            rec.ping  = s_axis_tdata[101:86];
            health_sb.note_record(rec);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            res.kind  = t_kind'(m_axis_tuser);
            res.addr  = m_axis_tdata[31:0];
            res.pre   = m_axis_tdata[37:32];
            res.start = m_axis_tdata[84:38];
            res.stop  = m_axis_tdata[131:85];
            res.open  = m_axis_tdata[132];
            res.last  = m_axis_tlast;
            health_sb.check_result(res);
        end
    end

    // -----------------------------------------------------------------------
    // driver tasks, all called at a falling edge
    // -----------------------------------------------------------------------
    task automatic send(t_record r);
        if (!no_idle && $urandom_range(99) < 11) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tuser  = r.flush;
        s_axis_tdata  = {2'b00, r.ping, r.tmo, r.pre, r.addr, r.ts};
        s_axis_tvalid = 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [46:0] rand_ts();
        return {15'($urandom_range(32767)), $urandom};
    endfunction

    // log record for pool key k; ping near the busy threshold mostly
    function automatic t_record log_rec(int k, bit tmo);
        t_record r;
        int      p;
        p = int'(health_sb.thr) + $urandom_range(60) - 30;
        if ($urandom_range(9) == 0) p = $urandom_range(65535);
        r.flush = 0;
        r.ts    = rand_ts();
        r.addr  = key_addr[k];
        r.pre   = key_pre[k];
        r.tmo   = tmo;
        r.ping  = (p < 0) ? 16'd0 : (p > 65535) ? 16'hffff : p[15:0];
        return r;
    endfunction

    // flush with random junk in the ignored fields
    function automatic t_record flush_rec();
        t_record r;
        r = log_rec($urandom_range(NKEYS - 1), $urandom_range(1));
        r.flush = 1;
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] v);
        i_cfg_we    = 1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        health_sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // idle the input, wait out every expected result and the block's own tail
    task automatic drain();
        s_axis_tvalid = 0;
        while (health_sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_burst(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) begin
                send(flush_rec());
            end else begin
                k = ($urandom_range(99) < 80) ? $urandom_range(5) : $urandom_range(NKEYS - 1);
                send(log_rec(k, $urandom_range(99) < 30));
            end
        end
        send(flush_rec());
    endtask

    task automatic setup(logic [15:0] lim, logic [15:0] len, logic [15:0] thr);
        drain();
        write_reg(REG_TROUBLE_LIMIT, lim);
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_LATENCY_THRESHOLD, thr);
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        t_record r;
        health_sb.clear();
        // extreme keys, a zero address with prefix 32, then random addresses
        key_addr[0] = 32'hffff_ffff; key_pre[0] = 6'd63;
        key_addr[1] = 32'h0;         key_pre[1] = 6'd0;
        key_addr[2] = 32'h0;         key_pre[2] = 6'd32;
        for (int k = 3; k < NKEYS; k++) begin
            key_addr[k] = $urandom;
            key_pre[k]  = k[5:0];
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: reset settings, trouble closed and reported
        r = log_rec(0, 1); r.ts = '1; send(r);
        send(log_rec(0, 1));
        send(log_rec(0, 1));
        r = log_rec(0, 0); r.ping = 16'h0; send(r);
        // busy opens on a full window of maximum pings
        repeat (3) begin
            r = log_rec(1, 0); r.ping = 16'hffff; send(r);
        end
        // trouble below the limit closes silently
        send(log_rec(2, 1));
        r = log_rec(2, 0); r.ping = 16'h0; send(r);
        // open trouble and open busy reported by flush
        repeat (3) send(log_rec(1, 1));
        r = log_rec(2, 1); r.ts = '0; send(r);
        send(flush_rec());
        // busy closes once the average falls
        repeat (3) begin
            r = log_rec(1, 0); r.ping = 16'hffff; send(r);
        end
        repeat (3) begin
            r = log_rec(1, 0); r.ping = 16'h0; send(r);
        end
        send(flush_rec());    // nothing open, no result

        // shrink the window on a full one, smallest limit, zero threshold
        setup(10'd1, 5'd1, 16'd0);
        random_burst(8);
        setup(10'd2, 5'd16, 16'd65535);
        random_burst(8);
        // out-of-range window lengths
        setup(10'd1, 5'd0, 16'd50);
        random_burst(8);
        setup(10'd2, 5'd31, 16'd120);
        random_burst(8);

        // no gaps on either side for a stretch
        no_idle = 1;
        setup(10'd3, 5'd4, 16'd80);
        random_burst(15);
        no_idle = 0;

        // largest limit: a short timeout run closes without a report
        setup(10'd1023, 5'd2, 16'd100);
        repeat (5) send(log_rec(3, 1));
        send(log_rec(3, 0));

        // back-pressure: receiver holds off while flush results pile up
        setup(10'd1, 5'd1, 16'd0);
        hold_cycles = 400;
        for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 6; k++) send(log_rec(k, 0));
            for (int k = 0; k < 6; k++) send(log_rec(k, 1));
            send(flush_rec());
        end

        // fill the table; later new keys get dropped
        setup(10'd3, 5'd3, 16'd100);
        for (int k = 0; k < NKEYS; k++) send(log_rec(k, $urandom_range(1)));
        random_burst(5);

        drain();
        if (health_sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/soom_pkg.sv
hw/rtl/soom_ram.sv
hw/rtl/soom_cell.sv
hw/rtl/server_outage_overload_monitor.sv
tb/tb_server_outage_overload_monitor.sv
